/* hw/rtl/nfsa_pkg.sv */
// Shared types and constants of the next-fit slot allocator.
`timescale 1ns / 1ps

package nfsa_pkg;

   localparam int DEF_NUM_SLOTS = 32;
   localparam int SLOT_W        = 5;
   localparam int OWNER_W       = 16;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NONE_FREE    = 2'd1,
      ST_ALREADY_FREE = 2'd2
   } status_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [OWNER_W-1:0]  owner_id;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   granted_slot;
      logic                any_busy;
   } rsp_type;

endpackage

/* hw/rtl/nfsa_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface nfsa_req_if;
   import nfsa_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface nfsa_rsp_if;
   import nfsa_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/next_fit_slot_allocator.sv */
// Next-fit slot allocator: taken map, rotated free-slot search, owner store.
//
// Requests enter on req_ch (op, slot, owner_id); one result per request
// leaves on rsp_ch (status, granted_slot, any_busy). Both are valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// A request is captured in an input register, handled by the rotated
// priority encode over the taken map once the output register is empty or
// being read, and its result then lands in the output register, which
// drives rsp valid. Throughput is one request per cycle while rsp_ch does
// not stall; the combinational search and map update set that figure.
// Allocate starts just after the last granted slot and wraps; when no
// slot is free the status says so and nothing changes.
// When the receiver stalls, the result register holds, the input register
// holds one more request, and req_ch.ready then drops until rsp_ch moves.
// Reset (synchronous, active high) frees every slot, sets the last granted
// slot to zero so the first search begins at slot one, and empties both
// registers. Owner ids are stored per granted slot and have no reset.
`timescale 1ns / 1ps

module next_fit_slot_allocator #(
   parameter int NUM_SLOTS = nfsa_pkg::DEF_NUM_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   nfsa_req_if.sink   req_ch,
   nfsa_rsp_if.source rsp_ch
);
   import nfsa_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CMP_W = IDX_W + SLOT_W + 1;

   logic                 in_valid_ff;
   req_type              in_req_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_rsp_ff, out_rsp_in;
   logic [NUM_SLOTS-1:0] taken_ff, taken_in;
   logic [IDX_W-1:0]     last_ff, last_in;
   logic [OWNER_W-1:0]   owner_table_ff [NUM_SLOTS];

   logic                 advance;
   logic [IDX_W-1:0]     start_idx;
   logic [NUM_SLOTS-1:0] free_map, upper_free;
   logic [IDX_W-1:0]     upper_idx, any_idx, grant_idx;
   logic                 grant;
   logic [CMP_W-1:0]     slot_ext;
   logic                 slot_ok;
   logic [IDX_W-1:0]     slot_idx;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_rsp_ff;

   assign start_idx = (last_ff == IDX_W'(NUM_SLOTS - 1)) ? '0 : last_ff + 1'b1;
   assign free_map  = ~taken_ff;

   always_comb begin
      upper_free = '0;
      upper_idx  = '0;
      any_idx    = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         upper_free[i] = free_map[i] && (IDX_W'(i) >= start_idx);
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (upper_free[i]) begin
            upper_idx = IDX_W'(i);
         end
         if (free_map[i]) begin
            any_idx = IDX_W'(i);
         end
      end
   end

   assign grant_idx = (|upper_free) ? upper_idx : any_idx;
   assign slot_ext  = CMP_W'(in_req_ff.slot);
   assign slot_ok   = slot_ext < CMP_W'(NUM_SLOTS);
   assign slot_idx  = slot_ext[IDX_W-1:0];
   assign grant     = advance && (in_req_ff.op == OP_ALLOC) && (|free_map);

   always_comb begin
      taken_in     = taken_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         out_valid_in            = 1'b1;
         out_rsp_in.status       = ST_OK;
         out_rsp_in.granted_slot = '0;
         unique case (in_req_ff.op)
            OP_ALLOC: begin
               if (|free_map) begin
                  taken_in[grant_idx]     = 1'b1;
                  last_in                 = grant_idx;
                  out_rsp_in.granted_slot = SLOT_W'(grant_idx);
               end else begin
                  out_rsp_in.status = ST_NONE_FREE;
               end
            end
            OP_FREE: begin
               if (slot_ok && taken_ff[slot_idx]) begin
                  taken_in[slot_idx] = 1'b0;
               end else begin
                  out_rsp_in.status = ST_ALREADY_FREE;
               end
            end
            default: begin
               out_rsp_in.status = ST_OK;
            end
         endcase
         out_rsp_in.any_busy = |taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         taken_ff     <= '0;
         last_ff      <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         out_valid_ff <= out_valid_in;
         taken_ff     <= taken_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_req_ff <= req_ch.payload;
      end
      out_rsp_ff <= out_rsp_in;
   end

   always_ff @(posedge clock) begin
      if (grant) begin
         owner_table_ff[grant_idx] <= in_req_ff.owner_id;
      end
   end

endmodule

/* dv/next_fit_slot_allocator_tb.sv */
// Self-checking testbench for the next-fit slot allocator.
`timescale 1ns / 1ps

module next_fit_slot_allocator_tb;
   import nfsa_pkg::*;

   localparam int NUM_SLOTS   = DEF_NUM_SLOTS;
   localparam int CYCLE_LIMIT = 60000;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_LEN   = 40;
   localparam int MAX_PRINTS  = 60;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;

   nfsa_req_if req_if ();
   nfsa_rsp_if rsp_if ();

   next_fit_slot_allocator #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   logic [NUM_SLOTS-1:0] slot_taken;
   logic [SLOT_W-1:0]    last_grant;
   rsp_type              pending_rsp_q[$];
   int unsigned          mismatch_count;
   int unsigned          cycle_count;
   bit                   req_gaps;
   bit                   rsp_gaps;

   directed_row_type directed_tab [16] = '{
      '{'{OP_FREE,  5'd0,  16'h0000}, 1'b1, '{ST_ALREADY_FREE, 5'd0, 1'b0}},
      '{'{OP_FREE,  5'd31, 16'hffff}, 1'b1, '{ST_ALREADY_FREE, 5'd0, 1'b0}},
      '{'{OP_ALLOC, 5'd31, 16'h0000}, 1'b1, '{ST_OK,           5'd1, 1'b1}},
      '{'{OP_ALLOC, 5'd0,  16'hffff}, 1'b1, '{ST_OK,           5'd2, 1'b1}},
      '{'{OP_ALLOC, 5'd21, 16'h5555}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd2,  16'haaaa}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd2,  16'haaaa}, 1'b1, '{ST_ALREADY_FREE, 5'd0, 1'b1}},
      '{'{OP_ALLOC, 5'd10, 16'h1234}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd1,  16'h0001}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd3,  16'h8000}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd4,  16'h7fff}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd10, 16'h0f0f}, 1'b1, '{ST_ALREADY_FREE, 5'd0, 1'b0}},
      '{'{OP_ALLOC, 5'd31, 16'hffff}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd5,  16'h0000}, 1'b0, '{ST_OK,           5'd0, 1'b0}},
      '{'{OP_FREE,  5'd31, 16'hffff}, 1'b1, '{ST_ALREADY_FREE, 5'd0, 1'b0}},
      '{'{OP_ALLOC, 5'd0,  16'h8001}, 1'b0, '{ST_OK,           5'd0, 1'b0}}
   };

   always #6 clock = ~clock;

   function automatic rsp_type predict_allocation(input req_type r);
      rsp_type res;
      int      idx;
      bit      found;
      res   = '{ST_OK, '0, 1'b0};
      found = 1'b0;
      if (r.op == OP_ALLOC) begin
         for (int n = 1; n <= NUM_SLOTS && !found; n++) begin
            idx = (int'(last_grant) + n) % NUM_SLOTS;
            if (!slot_taken[idx]) begin
               slot_taken[idx]  = 1'b1;
               last_grant       = idx[SLOT_W-1:0];
               res.granted_slot = idx[SLOT_W-1:0];
               found            = 1'b1;
            end
         end
         if (!found) begin
            res.status = ST_NONE_FREE;
         end
      end else begin
         if (int'(r.slot) >= NUM_SLOTS || !slot_taken[r.slot]) begin
            res.status = ST_ALREADY_FREE;
         end else begin
            slot_taken[r.slot] = 1'b0;
         end
      end
      res.any_busy = |slot_taken;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Call at a falling edge; returns at the falling edge after acceptance.
   task automatic issue_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int unsigned gap;
      rsp_type     predicted;
      gap = req_gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload <= r;
      req_if.valid   <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predicted = predict_allocation(r);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("result with no request pending");
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_if.payload.status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d",
                  rsp_if.payload.status, want.status));
            end
            if (rsp_if.payload.granted_slot !== want.granted_slot) begin
               report_mismatch($sformatf("granted_slot %0d, want %0d",
                  rsp_if.payload.granted_slot, want.granted_slot));
            end
            if (rsp_if.payload.any_busy !== want.any_busy) begin
               report_mismatch($sformatf("any_busy %0b, want %0b",
                  rsp_if.payload.any_busy, want.any_busy));
            end
         end
      end
   end

   initial begin : result_sink
      bit          taken;
      int unsigned stall;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         taken = rsp_if.valid && rsp_if.ready;
         @(negedge clock);
         if (taken) begin
            stall = rsp_gaps ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(negedge clock);
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      req_type     r;
      int unsigned alloc_pct;
      int unsigned start;
      bit          picked;
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '{OP_ALLOC, '0, '0};
      slot_taken     = '0;
      last_grant     = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      req_gaps       = 1'b1;
      rsp_gaps       = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_tab[i]) begin
         issue_request(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].rsp);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph % 4)
            0: alloc_pct = 95;
            1: alloc_pct = 50;
            2: alloc_pct = 10;
            default: alloc_pct = 70;
         endcase
         req_gaps = ($urandom_range(0, 2) != 0);
         rsp_gaps = ($urandom_range(0, 2) != 0);
         if (ph == RAND_PHASES / 2) begin
            req_if.valid <= 1'b0;
            wait (pending_rsp_q.size() == 0);
            @(negedge clock);
         end
         for (int k = 0; k < PHASE_LEN; k++) begin
            r.owner_id = OWNER_W'($urandom);
            r.slot     = SLOT_W'($urandom);
            if ($urandom_range(0, 99) < alloc_pct) begin
               r.op = OP_ALLOC;
            end else begin
               r.op = OP_FREE;
               if ($urandom_range(0, 3) != 0) begin
                  start  = $urandom_range(0, NUM_SLOTS - 1);
                  picked = 1'b0;
                  for (int s = 0; s < NUM_SLOTS && !picked; s++) begin
                     if (slot_taken[(start + s) % NUM_SLOTS]) begin
                        r.slot = SLOT_W'((start + s) % NUM_SLOTS);
                        picked = 1'b1;
                     end
                  end
               end
            end
            issue_request(r, 1'b0, '{ST_OK, '0, 1'b0});
         end
      end

      req_if.valid <= 1'b0;
      wait (pending_rsp_q.size() == 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/nfsa_pkg.sv
hw/rtl/nfsa_if.sv
hw/rtl/next_fit_slot_allocator.sv
dv/next_fit_slot_allocator_tb.sv
